[sv/mcdc_pkg.sv]
// ----------------------------------------------------------------------------
// mcdc_pkg
// Shared types, codes and defaults for the mouse click/drag classifier.
// ----------------------------------------------------------------------------
package mcdc_pkg;

  // Default sizes handed to the top level parameters
  localparam int NUM_BINDINGS_DEF = 30;
  localparam int COORD_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF   = 16;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 16;
  localparam int BIND_W   = 5;
  localparam int CLASS_W  = 3;
  localparam int MASK_W   = 32;
  localparam int RATE_W   = 10;

  // Bit positions in the held mask
  localparam int LEFT_BIT  = 0;
  localparam int RIGHT_BIT = 1;
  localparam int KEY_BASE  = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;

  localparam logic [RATE_W-1:0] FRAME_RATE_RST = RATE_W'(60);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FROZEN     = 2'd0,
    REG_FRAME_RATE = 2'd1
  } cfg_reg_e;

  // Input event codes
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 3'd0,
    MODE_MOVE     = 3'd1,
    MODE_BTN_DOWN = 3'd2,
    MODE_BTN_UP   = 3'd3,
    MODE_KEY_DOWN = 3'd4,
    MODE_KEY_UP   = 3'd5
  } mode_e;

  // Result classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE     = 3'd0,
    CLS_DRAG     = 3'd1,
    CLS_RCLICK   = 3'd2,
    CLS_LCLICK   = 3'd3,
    CLS_DRELEASE = 3'd4,
    CLS_KPRESS   = 3'd5,
    CLS_KRELEASE = 3'd6
  } class_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              button_right;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              binding_valid;
    logic [BIND_W-1:0] binding_index;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] event_class;
    logic [MASK_W-1:0]  held_mask;
  } out_item_t;

endpackage

[sv/mcdc_step.sv]
// ----------------------------------------------------------------------------
// mcdc_step
// Next-state and classification logic for one event item.
// ----------------------------------------------------------------------------
module mcdc_step #(
  parameter int NUM_BINDINGS = mcdc_pkg::NUM_BINDINGS_DEF,
  parameter int COORD_BITS   = mcdc_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS   = mcdc_pkg::COUNT_BITS_DEF
) (
  input  logic                            frozen,
  input  logic [mcdc_pkg::RATE_W-1:0]     frame_rate,
  input  mcdc_pkg::in_item_t              item,
  input  logic [mcdc_pkg::MASK_W-1:0]     held,
  input  logic [COORD_BITS-1:0]           lpx,
  input  logic [COORD_BITS-1:0]           lpy,
  input  logic [COORD_BITS-1:0]           rpx,
  input  logic [COORD_BITS-1:0]           rpy,
  input  logic [COUNT_BITS-1:0]           lfr,
  input  logic [COUNT_BITS-1:0]           rfr,
  output logic [mcdc_pkg::MASK_W-1:0]     held_nxt,
  output logic [COORD_BITS-1:0]           lpx_nxt,
  output logic [COORD_BITS-1:0]           lpy_nxt,
  output logic [COORD_BITS-1:0]           rpx_nxt,
  output logic [COORD_BITS-1:0]           rpy_nxt,
  output logic [COUNT_BITS-1:0]           lfr_nxt,
  output logic [COUNT_BITS-1:0]           rfr_nxt,
  output mcdc_pkg::out_item_t             result
);

  localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [31:0]               x_ext;
  logic [31:0]               y_ext;
  logic [COORD_BITS-1:0]     x_c;
  logic [COORD_BITS-1:0]     y_c;
  logic                      l_same;
  logic                      r_same;
  logic                      l_in_time;
  logic                      r_in_time;
  logic                      key_ok;
  logic [mcdc_pkg::MASK_W-1:0] key_bit;
  logic [COUNT_BITS-1:0]     lfr_inc;
  logic [COUNT_BITS-1:0]     rfr_inc;
  logic [mcdc_pkg::CLASS_W-1:0] cls;

  // Positions reduced to the stored coordinate width
  assign x_ext = 32'(item.pos_x);
  assign y_ext = 32'(item.pos_y);
  assign x_c   = x_ext[COORD_BITS-1:0];
  assign y_c   = y_ext[COORD_BITS-1:0];

  assign l_same = (lpx == x_c) && (lpy == y_c);
  assign r_same = (rpx == x_c) && (rpy == y_c);

  // Click window: frame_rate >= 2 * elapsed frames
  assign l_in_time = 34'(frame_rate) >= (34'(lfr) << 1);
  assign r_in_time = 34'(frame_rate) >= (34'(rfr) << 1);

  // Saturating frame counters
  assign lfr_inc = (lfr == '1) ? lfr : lfr + CNT_ONE;
  assign rfr_inc = (rfr == '1) ? rfr : rfr + CNT_ONE;

  // Key binding must be valid and land inside the mask
  assign key_ok  = item.binding_valid
                   && (6'(item.binding_index) < 6'(NUM_BINDINGS))
                   && (6'(item.binding_index) + 6'(mcdc_pkg::KEY_BASE) < 6'(mcdc_pkg::MASK_W));
  assign key_bit = mcdc_pkg::MASK_W'(1) << (6'(item.binding_index) + 6'(mcdc_pkg::KEY_BASE));

  always_comb begin
    held_nxt = held;
    lpx_nxt  = lpx;
    lpy_nxt  = lpy;
    rpx_nxt  = rpx;
    rpy_nxt  = rpy;
    lfr_nxt  = lfr;
    rfr_nxt  = rfr;
    cls      = mcdc_pkg::CLS_NONE;
    unique case (item.mode)
      mcdc_pkg::MODE_TICK: begin
        lfr_nxt = lfr_inc;
        rfr_nxt = rfr_inc;
      end
      mcdc_pkg::MODE_MOVE: begin
        if (!frozen && held[mcdc_pkg::LEFT_BIT]) begin
          cls = mcdc_pkg::CLS_DRAG;
        end
      end
      mcdc_pkg::MODE_BTN_DOWN: begin
        if (!frozen) begin
          if (item.button_right) begin
            held_nxt[mcdc_pkg::RIGHT_BIT] = 1'b1;
            rpx_nxt = x_c;
            rpy_nxt = y_c;
            rfr_nxt = '0;
          end else begin
            held_nxt[mcdc_pkg::LEFT_BIT] = 1'b1;
            lpx_nxt = x_c;
            lpy_nxt = y_c;
            lfr_nxt = '0;
          end
        end
      end
      mcdc_pkg::MODE_BTN_UP: begin
        // release clears the held bit even when frozen
        if (item.button_right) begin
          held_nxt[mcdc_pkg::RIGHT_BIT] = 1'b0;
          if (!frozen && r_same && r_in_time) begin
            cls = mcdc_pkg::CLS_RCLICK;
          end
        end else begin
          held_nxt[mcdc_pkg::LEFT_BIT] = 1'b0;
          if (!frozen) begin
            priority if (l_same && l_in_time) begin
              cls = mcdc_pkg::CLS_LCLICK;
            end else if (!l_same) begin
              cls = mcdc_pkg::CLS_DRELEASE;
            end else begin
              cls = mcdc_pkg::CLS_NONE;
            end
          end
        end
      end
      mcdc_pkg::MODE_KEY_DOWN: begin
        if (key_ok) begin
          held_nxt = held | key_bit;
          cls      = mcdc_pkg::CLS_KPRESS;
        end
      end
      mcdc_pkg::MODE_KEY_UP: begin
        if (key_ok) begin
          held_nxt = held & ~key_bit;
          cls      = mcdc_pkg::CLS_KRELEASE;
        end
      end
      default: begin
        cls = mcdc_pkg::CLS_NONE;
      end
    endcase
  end

  assign result.event_class = cls;
  assign result.held_mask   = held_nxt;

endmodule

[sv/mouse_click_drag_classifier.sv]
// ----------------------------------------------------------------------------
// mouse_click_drag_classifier
// Classifies input events into drags, clicks, drag releases and key events
// while tracking held buttons and keys.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------
//  input   | in_valid, in_stall, in_item    | mcdc_pkg::in_item_t
//  result  | out_valid, out_stall, out_item | mcdc_pkg::out_item_t
//  config  | cfg_valid, cfg_ready, cfg_*    | index + write data
//
//  One item per cycle while out_stall does not hold the result register;
//  an accepted item goes through the input register, then the result
//  register, to out_item. All state updates happen in one pass of logic
//  between the two registers.
//  out_stall holds the result register; in_stall rises only when both
//  stages are full and the result is stalled.
//  Synchronous rst_n clears valids, tracking state, frozen; frame_rate = 60.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module mouse_click_drag_classifier #(
  parameter int NUM_BINDINGS = mcdc_pkg::NUM_BINDINGS_DEF,
  parameter int COORD_BITS   = mcdc_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS   = mcdc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mcdc_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mcdc_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcdc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                            frozen_r;
  logic [mcdc_pkg::RATE_W-1:0]     frame_rate_r;

  logic                            s1_valid_r;
  mcdc_pkg::in_item_t              s1_item_r;
  logic                            out_valid_r;
  mcdc_pkg::out_item_t             out_item_r;

  logic [mcdc_pkg::MASK_W-1:0]     held_r;
  logic [COORD_BITS-1:0]           lpx_r;
  logic [COORD_BITS-1:0]           lpy_r;
  logic [COORD_BITS-1:0]           rpx_r;
  logic [COORD_BITS-1:0]           rpy_r;
  logic [COUNT_BITS-1:0]           lfr_r;
  logic [COUNT_BITS-1:0]           rfr_r;

  logic [mcdc_pkg::MASK_W-1:0]     held_nxt;
  logic [COORD_BITS-1:0]           lpx_nxt;
  logic [COORD_BITS-1:0]           lpy_nxt;
  logic [COORD_BITS-1:0]           rpx_nxt;
  logic [COORD_BITS-1:0]           rpy_nxt;
  logic [COUNT_BITS-1:0]           lfr_nxt;
  logic [COUNT_BITS-1:0]           rfr_nxt;
  mcdc_pkg::out_item_t             result;

  logic s1_adv;
  logic in_take;

  // Handshake control
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r     <= 1'b0;
      frame_rate_r <= mcdc_pkg::FRAME_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcdc_pkg::REG_FROZEN:     frozen_r     <= cfg_data[0];
        mcdc_pkg::REG_FRAME_RATE: frame_rate_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  mcdc_step #(
    .NUM_BINDINGS (NUM_BINDINGS),
    .COORD_BITS   (COORD_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_step (
    .frozen     (frozen_r),
    .frame_rate (frame_rate_r),
    .item       (s1_item_r),
    .held       (held_r),
    .lpx        (lpx_r),
    .lpy        (lpy_r),
    .rpx        (rpx_r),
    .rpy        (rpy_r),
    .lfr        (lfr_r),
    .rfr        (rfr_r),
    .held_nxt   (held_nxt),
    .lpx_nxt    (lpx_nxt),
    .lpy_nxt    (lpy_nxt),
    .rpx_nxt    (rpx_nxt),
    .rpy_nxt    (rpy_nxt),
    .lfr_nxt    (lfr_nxt),
    .rfr_nxt    (rfr_nxt),
    .result     (result)
  );

  // Tracking state, updated as each item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      lpx_r  <= '0;
      lpy_r  <= '0;
      rpx_r  <= '0;
      rpy_r  <= '0;
      lfr_r  <= '0;
      rfr_r  <= '0;
    end else if (s1_adv) begin
      held_r <= held_nxt;
      lpx_r  <= lpx_nxt;
      lpy_r  <= lpy_nxt;
      rpx_r  <= rpx_nxt;
      rpy_r  <= rpy_nxt;
      lfr_r  <= lfr_nxt;
      rfr_r  <= rfr_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

endmodule

[sv/mcdc_checker.sv]
// ----------------------------------------------------------------------------
// mcdc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module mcdc_checker #(
  parameter int NUM_BINDINGS = mcdc_pkg::NUM_BINDINGS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input mcdc_pkg::out_item_t out_item
);

  localparam int TOP_BIT = (NUM_BINDINGS + mcdc_pkg::KEY_BASE < mcdc_pkg::MASK_W)
                           ? NUM_BINDINGS + mcdc_pkg::KEY_BASE : mcdc_pkg::MASK_W;
  localparam logic [mcdc_pkg::MASK_W-1:0] LEGAL_MASK =
    mcdc_pkg::MASK_W'((64'd1 << TOP_BIT) - 64'd1);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // No key bit outside the bindings
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.held_mask & ~LEGAL_MASK) == '0)
    else $error("held mask has a bit beyond the bindings");

  // A drag needs the left button held
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_class == mcdc_pkg::CLS_DRAG
      |-> out_item.held_mask[mcdc_pkg::LEFT_BIT])
    else $error("drag without left button held");

  // A left click or drag release leaves the left button up
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_class == mcdc_pkg::CLS_LCLICK ||
                  out_item.event_class == mcdc_pkg::CLS_DRELEASE)
      |-> !out_item.held_mask[mcdc_pkg::LEFT_BIT])
    else $error("left release with left button still held");

  // A right click leaves the right button up
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_class == mcdc_pkg::CLS_RCLICK
      |-> !out_item.held_mask[mcdc_pkg::RIGHT_BIT])
    else $error("right click with right button still held");

endmodule

bind mouse_click_drag_classifier mcdc_checker #(
  .NUM_BINDINGS (NUM_BINDINGS)
) u_mcdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/mcdc_checker.sv]
// ----------------------------------------------------------------------------
// mcdc_scoreboard
// Watches the input, result and configuration channels of the click/drag
// classifier. It keeps its own copy of the held mask, press positions, frame
// counts and settings, predicts one result per accepted input item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mcdc_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  mcdc_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  mcdc_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mcdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              error_cnt,
  output int                              pending_cnt,
  output int                              result_cnt,
  output int                              click_cnt,
  output int                              drag_cnt,
  output int                              release_cnt,
  output int                              key_cnt
);

  localparam int FRAME_W = mcdc_pkg::COUNT_BITS_DEF;

  // Shadow state of the classifier
  logic [mcdc_pkg::MASK_W-1:0] held_q;
  logic [mcdc_pkg::POS_W-1:0]  left_x_q, left_y_q, right_x_q, right_y_q;
  logic [FRAME_W-1:0]          left_frames_q, right_frames_q;
  logic                        frozen_q;
  logic [mcdc_pkg::RATE_W-1:0] rate_q;

  // Predicted results, oldest first
  mcdc_pkg::out_item_t expected_q[$];

  // Frame counters stop at all ones
  function automatic logic [FRAME_W-1:0] bump(logic [FRAME_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Release is quick enough for a click when rate >= 2 * frames
  function automatic logic quick(logic [FRAME_W-1:0] frames);
    return int'(rate_q) >= 2 * int'(frames);
  endfunction

  // Apply one event to the shadow state and return the expected result
  function automatic mcdc_pkg::out_item_t classify(mcdc_pkg::in_item_t it);
    mcdc_pkg::out_item_t res;
    logic                same;
    int                  slot;
    res.event_class = mcdc_pkg::CLS_NONE;
    slot = int'(it.binding_index) + mcdc_pkg::KEY_BASE;
    case (it.mode)
      mcdc_pkg::MODE_TICK: begin
        left_frames_q  = bump(left_frames_q);
        right_frames_q = bump(right_frames_q);
      end
      mcdc_pkg::MODE_MOVE: begin
        if (!frozen_q && held_q[mcdc_pkg::LEFT_BIT]) res.event_class = mcdc_pkg::CLS_DRAG;
      end
      mcdc_pkg::MODE_BTN_DOWN: begin
        if (!frozen_q && it.button_right) begin
          held_q[mcdc_pkg::RIGHT_BIT] = 1'b1;
          right_x_q = it.pos_x;
          right_y_q = it.pos_y;
          right_frames_q = '0;
        end else if (!frozen_q) begin
          held_q[mcdc_pkg::LEFT_BIT] = 1'b1;
          left_x_q = it.pos_x;
          left_y_q = it.pos_y;
          left_frames_q = '0;
        end
      end
      mcdc_pkg::MODE_BTN_UP: begin
        if (it.button_right) begin
          held_q[mcdc_pkg::RIGHT_BIT] = 1'b0;
          if (!frozen_q && right_x_q == it.pos_x && right_y_q == it.pos_y &&
              quick(right_frames_q))
            res.event_class = mcdc_pkg::CLS_RCLICK;
        end else begin
          same = (left_x_q == it.pos_x) && (left_y_q == it.pos_y);
          held_q[mcdc_pkg::LEFT_BIT] = 1'b0;
          if (!frozen_q && same && quick(left_frames_q))
            res.event_class = mcdc_pkg::CLS_LCLICK;
          else if (!frozen_q && !same)
            res.event_class = mcdc_pkg::CLS_DRELEASE;
        end
      end
      mcdc_pkg::MODE_KEY_DOWN, mcdc_pkg::MODE_KEY_UP: begin
        // unmapped or out-of-range bindings leave everything alone
        if (it.binding_valid && it.binding_index < mcdc_pkg::NUM_BINDINGS_DEF &&
            slot < mcdc_pkg::MASK_W) begin
          if (it.mode == mcdc_pkg::MODE_KEY_DOWN) begin
            held_q[slot] = 1'b1;
            res.event_class = mcdc_pkg::CLS_KPRESS;
          end else begin
            held_q[slot] = 1'b0;
            res.event_class = mcdc_pkg::CLS_KRELEASE;
          end
        end
      end
      default: ;
    endcase
    res.held_mask = held_q;
    return res;
  endfunction

  // Channel monitor: config, then results, then new items
  always @(posedge clk) begin : watch
    mcdc_pkg::out_item_t want;
    if (!rst_n) begin
      held_q         = '0;
      left_x_q       = '0;
      left_y_q       = '0;
      right_x_q      = '0;
      right_y_q      = '0;
      left_frames_q  = '0;
      right_frames_q = '0;
      frozen_q       = 1'b0;
      rate_q         = mcdc_pkg::FRAME_RATE_RST;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mcdc_pkg::REG_FROZEN:     frozen_q = cfg_data[0];
          mcdc_pkg::REG_FRAME_RATE: rate_q   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_q.size() == 0) begin
          if (error_cnt < 10)
            $display("unexpected result: class %0d mask %h",
                     out_item.event_class, out_item.held_mask);
          error_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (want.event_class !== out_item.event_class ||
              want.held_mask !== out_item.held_mask) begin
            if (error_cnt < 10)
              $display("result %0d: expected class %0d mask %h, got class %0d mask %h",
                       result_cnt, want.event_class, want.held_mask,
                       out_item.event_class, out_item.held_mask);
            error_cnt++;
          end
          case (want.event_class)
            mcdc_pkg::CLS_LCLICK, mcdc_pkg::CLS_RCLICK:   click_cnt++;
            mcdc_pkg::CLS_DRAG:                           drag_cnt++;
            mcdc_pkg::CLS_DRELEASE:                       release_cnt++;
            mcdc_pkg::CLS_KPRESS, mcdc_pkg::CLS_KRELEASE: key_cnt++;
            default: ;
          endcase
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(classify(in_item));
    end
    pending_cnt = expected_q.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench top for the click/drag classifier: directed events for clicks,
// drags, key bindings, frozen mode and frame-rate limits, a tick burst with
// both buttons held, then random event sequences under several settings
// and sender/receiver idling patterns. Checking is in mcdc_scoreboard.
// ----------------------------------------------------------------------------
module tb;

  // modes the block does not use
  localparam logic [mcdc_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [mcdc_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 95;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_TICKS     = 30;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  mcdc_pkg::in_item_t              in_item   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  mcdc_pkg::out_item_t             out_item;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mcdc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mcdc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int sent_cnt     = 0;
  int quiet_cycles = 0;
  int error_cnt, pending_cnt, result_cnt, click_cnt, drag_cnt, release_cnt, key_cnt;

  always #4 clk = ~clk;

  mouse_click_drag_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mcdc_scoreboard chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_cnt   (error_cnt),
    .pending_cnt (pending_cnt),
    .result_cnt  (result_cnt),
    .click_cnt   (click_cnt),
    .drag_cnt    (drag_cnt),
    .release_cnt (release_cnt),
    .key_cnt     (key_cnt)
  );

  // Result-side backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: no handshake on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Fully random item, also used to fill don't-care fields
  function automatic mcdc_pkg::in_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(mcdc_pkg::in_item_t)-1:0];
  endfunction

  function automatic logic [mcdc_pkg::POS_W-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return mcdc_pkg::POS_W'($urandom);
    endcase
  endfunction

  // Offer one item, with random idle cycles first, and wait for acceptance
  task automatic send(mcdc_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_item  <= noise_item();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_plain(logic [mcdc_pkg::MODE_W-1:0] m);
    mcdc_pkg::in_item_t it;
    it = noise_item();
    it.mode = m;
    send(it);
  endtask

  task automatic send_btn(logic [mcdc_pkg::MODE_W-1:0] m, logic right,
                          logic [mcdc_pkg::POS_W-1:0] x, logic [mcdc_pkg::POS_W-1:0] y);
    mcdc_pkg::in_item_t it;
    it = noise_item();
    it.mode = m;
    it.button_right = right;
    it.pos_x = x;
    it.pos_y = y;
    send(it);
  endtask

  task automatic send_key(logic [mcdc_pkg::MODE_W-1:0] m, logic bvalid,
                          logic [mcdc_pkg::BIND_W-1:0] idx);
    mcdc_pkg::in_item_t it;
    it = noise_item();
    it.mode = m;
    it.binding_valid = bvalid;
    it.binding_index = idx;
    send(it);
  endtask

  // Stop sending and wait until every result is back and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(mcdc_pkg::cfg_reg_e idx, logic [mcdc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic frozen, logic [mcdc_pkg::RATE_W-1:0] rate);
    settle();
    write_reg(mcdc_pkg::REG_FROZEN, {{(mcdc_pkg::CFG_DATA_W-1){1'b0}}, frozen});
    write_reg(mcdc_pkg::REG_FRAME_RATE, rate);
  endtask

  // One well-formed gesture with random content, or a little noise
  task automatic random_scenario();
    logic                        right;
    logic [mcdc_pkg::POS_W-1:0]  x, y;
    logic [mcdc_pkg::BIND_W-1:0] idx;
    int                          n;
    right = 1'($urandom_range(0, 1));
    x     = pick_coord();
    y     = pick_coord();
    idx   = mcdc_pkg::BIND_W'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // press and release, mostly in place; sometimes slow
        send_btn(mcdc_pkg::MODE_BTN_DOWN, right, x, y);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 3);
        repeat (n)
          send_plain(($urandom_range(0, 3) == 0) ? mcdc_pkg::MODE_MOVE : mcdc_pkg::MODE_TICK);
        if ($urandom_range(0, 3) == 0) x[$urandom_range(0, mcdc_pkg::POS_W-1)] ^= 1'b1;
        if ($urandom_range(0, 5) == 0) y[$urandom_range(0, mcdc_pkg::POS_W-1)] ^= 1'b1;
        send_btn(mcdc_pkg::MODE_BTN_UP, right, x, y);
      end
      3, 4: begin
        // left drag ending somewhere else
        send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, x, y);
        repeat ($urandom_range(1, 6))
          send_plain(($urandom_range(0, 2) == 0) ? mcdc_pkg::MODE_TICK : mcdc_pkg::MODE_MOVE);
        send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, pick_coord(), pick_coord());
      end
      5, 6: begin
        // key press and release, occasionally unmapped
        send_key(mcdc_pkg::MODE_KEY_DOWN, $urandom_range(0, 9) != 0, idx);
        repeat ($urandom_range(0, 3))
          send_plain(($urandom_range(0, 1) == 0) ? mcdc_pkg::MODE_MOVE : mcdc_pkg::MODE_TICK);
        if ($urandom_range(0, 4) == 0) idx = mcdc_pkg::BIND_W'($urandom_range(0, 31));
        send_key(mcdc_pkg::MODE_KEY_UP, $urandom_range(0, 9) != 0, idx);
      end
      7: begin
        // both buttons and a key held together
        send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, x, y);
        send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, x, y);
        send_key(mcdc_pkg::MODE_KEY_DOWN, 1'b1, idx);
        send_plain(mcdc_pkg::MODE_MOVE);
        send_btn(mcdc_pkg::MODE_BTN_UP, 1'b1, x, y);
        send_key(mcdc_pkg::MODE_KEY_UP, 1'b1, idx);
        send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, x, y);
      end
      default: repeat ($urandom_range(1, 3)) send(noise_item());
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    int start;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, unused modes, clicks, drag, keys
    send_plain(mcdc_pkg::MODE_TICK);
    send_plain(MODE_SPARE_A);
    send_plain(MODE_SPARE_B);
    send_plain(mcdc_pkg::MODE_MOVE);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, '0, '0);
    send_plain(mcdc_pkg::MODE_MOVE);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, '0, '0);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, '1, '1);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b1, '1, '1);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, 16'd1234, 16'd4321);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, 16'd1234, 16'd4322);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, 16'd10, 16'd10);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b1, 16'd11, 16'd10);
    send_key(mcdc_pkg::MODE_KEY_DOWN, 1'b1, 5'd0);
    send_key(mcdc_pkg::MODE_KEY_DOWN, 1'b1, 5'd29);
    send_key(mcdc_pkg::MODE_KEY_DOWN, 1'b1, 5'd30);
    send_key(mcdc_pkg::MODE_KEY_DOWN, 1'b1, 5'd31);
    send_key(mcdc_pkg::MODE_KEY_DOWN, 1'b0, 5'd5);
    send_key(mcdc_pkg::MODE_KEY_UP, 1'b1, 5'd29);
    send_key(mcdc_pkg::MODE_KEY_UP, 1'b1, 5'd0);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, 16'd7, 16'd7);

    // Frozen: move and presses ignored, release still clears the held bit
    set_config(1'b1, 10'd60);
    send_plain(mcdc_pkg::MODE_MOVE);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, 16'd7, 16'd7);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, 16'd7, 16'd7);

    // Frame-rate limit: in time vs. slow release at the press position
    set_config(1'b0, 10'd2);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, 16'd3, 16'd3);
    send_plain(mcdc_pkg::MODE_TICK);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, 16'd3, 16'd3);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, 16'd3, 16'd3);
    repeat (2) send_plain(mcdc_pkg::MODE_TICK);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, 16'd3, 16'd3);

    // Zero frame rate: only a release with no ticks in between clicks
    set_config(1'b0, 10'd0);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, 16'd4, 16'd4);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b1, 16'd4, 16'd4);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, 16'd4, 16'd4);
    send_plain(mcdc_pkg::MODE_TICK);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b1, 16'd4, 16'd4);

    // Both buttons held across a burst of ticks at the highest rate
    set_config(1'b0, 10'd1023);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b0, 16'd9, 16'd9);
    send_btn(mcdc_pkg::MODE_BTN_DOWN, 1'b1, 16'd8, 16'd8);
    repeat (HOLD_TICKS) send_plain(mcdc_pkg::MODE_TICK);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b0, 16'd9, 16'd9);
    send_btn(mcdc_pkg::MODE_BTN_UP, 1'b1, 16'd8, 16'd8);

    // Random gestures under several settings and idling patterns
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  set_config(1'b0, 10'd60);   end
        1: begin idle_pct = 48; stall_pct = 0;  set_config(1'b0, 10'd1023); end
        2: begin idle_pct = 0;  stall_pct = 48; set_config(1'b1, 10'd60);   end
        3: begin idle_pct = 16; stall_pct = 16; set_config(1'b0, 10'd1);    end
        default: begin idle_pct = 0; stall_pct = 48; set_config(1'b0, 10'd0); end
      endcase
      start = sent_cnt;
      while (sent_cnt - start < PHASE_ITEMS) begin
        random_scenario();
        // now and then let the block run completely dry
        if ($urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    repeat (8) @(negedge clk);
    $display("summary: %0d items sent, %0d results checked, %0d mismatches",
             sent_cnt, result_cnt, error_cnt);
    $display("summary: %0d clicks, %0d drags, %0d drag releases, %0d key events",
             click_cnt, drag_cnt, release_cnt, key_cnt);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
